// ===== sv/iigad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iigad_pkg
// Shared types and constants of the IMU impact and gyro anomaly detector.
// ----------------------------------------------------------------------------
package iigad_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ABS_W     = SAMPLE_W + 1;
  localparam int SQ_W      = 2 * SAMPLE_W - 1;
  localparam int MAG_W     = 2 * SAMPLE_W;
  localparam int RUN_W     = 8;
  localparam int HOLDOFF_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [HOLDOFF_W-1:0] HOLDOFF_SAMPLES = 9'd400;
  localparam logic [RUN_W-1:0]     RUN_MAX         = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSEC_NEED = 2'd2;

  localparam logic [15:0] IMPACT_THR_RST  = 16'd16384;
  localparam logic [15:0] GYRO_THR_RST    = 16'd12800;
  localparam logic [7:0]  CONSEC_NEED_RST = 8'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_z;
    logic            gyro_over;
    logic [1:0]      peak_axis;
  } feat_t;

endpackage

// ===== sv/iigad_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iigad_in_if
// Sample channel: one IMU sample per transfer.
// ----------------------------------------------------------------------------
interface iigad_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [iigad_pkg::SAMPLE_W-1:0] accel_x;
  logic signed [iigad_pkg::SAMPLE_W-1:0] accel_y;
  logic signed [iigad_pkg::SAMPLE_W-1:0] accel_z;
  logic signed [iigad_pkg::SAMPLE_W-1:0] rate_x;
  logic signed [iigad_pkg::SAMPLE_W-1:0] rate_y;
  logic signed [iigad_pkg::SAMPLE_W-1:0] rate_z;
  logic                                   armed;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, armed,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, armed,
                output ready);
endinterface

// ===== sv/iigad_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iigad_out_if
// Result channel: alert flags and peak rate axis, one transfer per sample.
// ----------------------------------------------------------------------------
interface iigad_out_if;
  logic       valid;
  logic       ready;
  logic       impact_alert;
  logic       gyro_alert;
  logic [1:0] peak_axis;

  modport source (output valid, impact_alert, gyro_alert, peak_axis, input ready);
  modport sink (input valid, impact_alert, gyro_alert, peak_axis, output ready);
endinterface

// ===== sv/iigad_feature.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iigad_feature
// Per-sample features: squared acceleration axes, peak rate axis and the
// per-axis rate threshold test.
// ----------------------------------------------------------------------------
module iigad_feature (
  input  logic signed [iigad_pkg::SAMPLE_W-1:0] accel_x,
  input  logic signed [iigad_pkg::SAMPLE_W-1:0] accel_y,
  input  logic signed [iigad_pkg::SAMPLE_W-1:0] accel_z,
  input  logic signed [iigad_pkg::SAMPLE_W-1:0] rate_x,
  input  logic signed [iigad_pkg::SAMPLE_W-1:0] rate_y,
  input  logic signed [iigad_pkg::SAMPLE_W-1:0] rate_z,
  input  logic [15:0]                            gyro_threshold,
  output iigad_pkg::feat_t                       feat
);

  function automatic logic [iigad_pkg::ABS_W-1:0] abs_rate(
    input logic signed [iigad_pkg::SAMPLE_W-1:0] v
  );
    logic signed [iigad_pkg::ABS_W-1:0] e;
    e = {v[iigad_pkg::SAMPLE_W-1], v};
    return e[iigad_pkg::ABS_W-1] ? iigad_pkg::ABS_W'(-e) : iigad_pkg::ABS_W'(e);
  endfunction

  logic signed [iigad_pkg::MAG_W-1:0] prod_x;
  logic signed [iigad_pkg::MAG_W-1:0] prod_y;
  logic signed [iigad_pkg::MAG_W-1:0] prod_z;
  logic [iigad_pkg::ABS_W-1:0]        abs_x;
  logic [iigad_pkg::ABS_W-1:0]        abs_y;
  logic [iigad_pkg::ABS_W-1:0]        abs_z;
  logic [iigad_pkg::ABS_W-1:0]        peak_val;
  logic [1:0]                         peak_axis;

  assign prod_x = iigad_pkg::MAG_W'(accel_x) * iigad_pkg::MAG_W'(accel_x);
  assign prod_y = iigad_pkg::MAG_W'(accel_y) * iigad_pkg::MAG_W'(accel_y);
  assign prod_z = iigad_pkg::MAG_W'(accel_z) * iigad_pkg::MAG_W'(accel_z);

  assign abs_x = abs_rate(rate_x);
  assign abs_y = abs_rate(rate_y);
  assign abs_z = abs_rate(rate_z);

  // Ties keep the lower axis.
  always_comb begin
    peak_val  = abs_x;
    peak_axis = iigad_pkg::AXIS_X;
    if (abs_y > peak_val) begin
      peak_val  = abs_y;
      peak_axis = iigad_pkg::AXIS_Y;
    end
    if (abs_z > peak_val) begin
      peak_val  = abs_z;
      peak_axis = iigad_pkg::AXIS_Z;
    end
  end

  always_comb begin
    feat.sq_x      = prod_x[iigad_pkg::SQ_W-1:0];
    feat.sq_y      = prod_y[iigad_pkg::SQ_W-1:0];
    feat.sq_z      = prod_z[iigad_pkg::SQ_W-1:0];
    feat.gyro_over = peak_val > {1'b0, gyro_threshold};
    feat.peak_axis = peak_axis;
  end

endmodule

// ===== sv/imu_impact_gyro_anomaly_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_impact_gyro_anomaly_detector
// Debounced impact and gyro rate alerts with a gyro alert holdoff.
//
// The sample channel carries three acceleration axes, three rate axes and the
// armed flag; the result channel returns one item per sample with the impact
// alert, the gyro alert and the axis of the largest absolute rate.
// Thresholds and the run length are written on the cfg port while idle.
// A sample passes an input register, a feature register holding the squared
// accelerations and the rate test, and the result register, where the run
// counters, the impact latch and the holdoff counter are updated.
// One sample is taken per cycle while the receiver keeps up; the update of
// the detection state at the result register, once per sample, sets that
// rate.
// Every stage has its own valid bit, so an empty stage takes a sample even
// while a result waits; when the receiver stalls the stages fill and then the
// sample channel deasserts ready.
// Reset empties the pipeline, clears all detection state and restores the
// register defaults.
// ----------------------------------------------------------------------------
module imu_impact_gyro_anomaly_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  iigad_in_if.sink                         in_if,
  iigad_out_if.source                      out_if,
  input  logic                             cfg_we,
  input  logic [iigad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iigad_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [15:0] impact_thr_r;
  logic [15:0] gyro_thr_r;
  logic [7:0]  consec_need_r;
  logic [iigad_pkg::MAG_W-1:0] thr_sq_r;

  logic s1_valid_r;
  logic signed [iigad_pkg::SAMPLE_W-1:0] s1_ax_r, s1_ay_r, s1_az_r;
  logic signed [iigad_pkg::SAMPLE_W-1:0] s1_rx_r, s1_ry_r, s1_rz_r;
  logic s1_armed_r;

  logic              s2_valid_r;
  iigad_pkg::feat_t  s2_feat_r;
  logic              s2_armed_r;
  iigad_pkg::feat_t  feat;

  logic       out_valid_r;
  logic       out_impact_r, out_impact_nxt;
  logic       out_gyro_r, out_gyro_nxt;
  logic [1:0] out_peak_r;

  logic [iigad_pkg::RUN_W-1:0]     impact_run_r, impact_run_nxt;
  logic                            impact_latched_r, impact_latched_nxt;
  logic [iigad_pkg::RUN_W-1:0]     gyro_run_r, gyro_run_nxt;
  logic [iigad_pkg::HOLDOFF_W-1:0] gyro_holdoff_r, gyro_holdoff_nxt;

  logic out_free, s2_ready, s1_ready, state_step;
  logic [iigad_pkg::MAG_W-1:0]     mag_sq;
  logic                            impact_over;
  logic [iigad_pkg::RUN_W-1:0]     impact_inc, gyro_inc;
  logic [iigad_pkg::HOLDOFF_W-1:0] holdoff_dec;

  assign out_free   = !out_valid_r || out_if.ready;
  assign s2_ready   = !s2_valid_r || out_free;
  assign s1_ready   = !s1_valid_r || s2_ready;
  assign state_step = out_free && s2_valid_r;

  assign in_if.ready         = s1_ready;
  assign out_if.valid        = out_valid_r;
  assign out_if.impact_alert = out_impact_r;
  assign out_if.gyro_alert   = out_gyro_r;
  assign out_if.peak_axis    = out_peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      impact_thr_r  <= iigad_pkg::IMPACT_THR_RST;
      gyro_thr_r    <= iigad_pkg::GYRO_THR_RST;
      consec_need_r <= iigad_pkg::CONSEC_NEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        iigad_pkg::CFG_IMPACT_THR:  impact_thr_r  <= cfg_wdata;
        iigad_pkg::CFG_GYRO_THR:    gyro_thr_r    <= cfg_wdata;
        iigad_pkg::CFG_CONSEC_NEED: consec_need_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= iigad_pkg::MAG_W'(impact_thr_r) * iigad_pkg::MAG_W'(impact_thr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_if.valid) begin
      s1_ax_r    <= in_if.accel_x;
      s1_ay_r    <= in_if.accel_y;
      s1_az_r    <= in_if.accel_z;
      s1_rx_r    <= in_if.rate_x;
      s1_ry_r    <= in_if.rate_y;
      s1_rz_r    <= in_if.rate_z;
      s1_armed_r <= in_if.armed;
    end
  end

  iigad_feature u_feature (
    .accel_x        (s1_ax_r),
    .accel_y        (s1_ay_r),
    .accel_z        (s1_az_r),
    .rate_x         (s1_rx_r),
    .rate_y         (s1_ry_r),
    .rate_z         (s1_rz_r),
    .gyro_threshold (gyro_thr_r),
    .feat           (feat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_feat_r  <= feat;
      s2_armed_r <= s1_armed_r;
    end
  end

  assign mag_sq = iigad_pkg::MAG_W'(s2_feat_r.sq_x) + iigad_pkg::MAG_W'(s2_feat_r.sq_y)
                + iigad_pkg::MAG_W'(s2_feat_r.sq_z);
  assign impact_over = mag_sq > thr_sq_r;
  assign impact_inc  = (impact_run_r == iigad_pkg::RUN_MAX) ? impact_run_r
                     : impact_run_r + iigad_pkg::RUN_W'(1);
  assign gyro_inc    = (gyro_run_r == iigad_pkg::RUN_MAX) ? gyro_run_r
                     : gyro_run_r + iigad_pkg::RUN_W'(1);
  assign holdoff_dec = (gyro_holdoff_r != '0) ? gyro_holdoff_r - iigad_pkg::HOLDOFF_W'(1)
                                              : gyro_holdoff_r;

  always_comb begin
    impact_run_nxt     = impact_run_r;
    impact_latched_nxt = impact_latched_r;
    gyro_run_nxt       = gyro_run_r;
    gyro_holdoff_nxt   = gyro_holdoff_r;
    out_impact_nxt     = 1'b0;
    out_gyro_nxt       = 1'b0;
    if (!s2_armed_r) begin
      impact_run_nxt     = '0;
      impact_latched_nxt = 1'b0;
      gyro_run_nxt       = '0;
      gyro_holdoff_nxt   = '0;
    end else begin
      if (impact_over) begin
        impact_run_nxt = impact_inc;
        if (impact_inc >= consec_need_r && !impact_latched_r) begin
          impact_latched_nxt = 1'b1;
          out_impact_nxt     = 1'b1;
        end
      end else begin
        impact_run_nxt = '0;
      end
      gyro_holdoff_nxt = holdoff_dec;
      if (s2_feat_r.gyro_over) begin
        if (gyro_inc >= consec_need_r && holdoff_dec == '0) begin
          out_gyro_nxt     = 1'b1;
          gyro_run_nxt     = '0;
          gyro_holdoff_nxt = iigad_pkg::HOLDOFF_SAMPLES;
        end else begin
          gyro_run_nxt = gyro_inc;
        end
      end else begin
        gyro_run_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r      <= 1'b0;
      impact_run_r     <= '0;
      impact_latched_r <= 1'b0;
      gyro_run_r       <= '0;
      gyro_holdoff_r   <= '0;
    end else begin
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
      if (state_step) begin
        impact_run_r     <= impact_run_nxt;
        impact_latched_r <= impact_latched_nxt;
        gyro_run_r       <= gyro_run_nxt;
        gyro_holdoff_r   <= gyro_holdoff_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_step) begin
      out_impact_r <= out_impact_nxt;
      out_gyro_r   <= out_gyro_nxt;
      out_peak_r   <= s2_feat_r.peak_axis;
    end
  end

  // An impact alert on the result always leaves the latch set behind it.
  a_impact_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.impact_alert |-> impact_latched_r)
    else $error("impact alert without latch");

  // A gyro alert restarts the holdoff and clears the run.
  a_gyro_holdoff_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.gyro_alert |->
      gyro_holdoff_r == iigad_pkg::HOLDOFF_SAMPLES && gyro_run_r == '0)
    else $error("gyro alert did not load holdoff");

  a_holdoff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gyro_holdoff_r <= iigad_pkg::HOLDOFF_SAMPLES)
    else $error("gyro holdoff above its load value");

  // Detection state moves only when a result is loaded.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !state_step |=> $stable(impact_latched_r) && $stable(gyro_holdoff_r))
    else $error("detection state changed without a result");

  a_peak_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.peak_axis != 2'd3)
    else $error("peak axis out of range");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IMU impact and gyro anomaly detector.
//
// A short directed list covers disarm clearing, exact-threshold samples,
// the most negative rate, ties for the peak axis, the holdoff, a run length
// of zero and a write to the unused register slot. Then randomized phases
// under several thresholds (extremes included) stream runs of quiet,
// over-threshold, boundary and noise samples. A local detector model predicts
// every result that no directed row gives, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam logic [iigad_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [1:0] AXIS_CODE [3] = '{iigad_pkg::AXIS_X, iigad_pkg::AXIS_Y,
                                           iigad_pkg::AXIS_Z};

  typedef struct packed {
    logic signed [iigad_pkg::SAMPLE_W-1:0] ax;
    logic signed [iigad_pkg::SAMPLE_W-1:0] ay;
    logic signed [iigad_pkg::SAMPLE_W-1:0] az;
    logic signed [iigad_pkg::SAMPLE_W-1:0] rx;
    logic signed [iigad_pkg::SAMPLE_W-1:0] ry;
    logic signed [iigad_pkg::SAMPLE_W-1:0] rz;
    logic                                  armed;
  } sample_t;

  typedef struct packed {
    logic       impact;
    logic       gyro;
    logic [1:0] peak;
  } verdict_t;

  typedef enum logic {ROW_SAMPLE, ROW_SETTING} row_kind_t;
  typedef enum logic [1:0] {SHAPE_QUIET, SHAPE_HIT, SHAPE_EDGE, SHAPE_NOISE} shape_t;
  typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_CHOKED} rx_mode_t;

  typedef struct {
    row_kind_t                       kind;
    logic [iigad_pkg::CFG_IDX_W-1:0] idx;
    logic [iigad_pkg::CFG_W-1:0]     data;
    sample_t                         smp;
    bit                              typed;
    verdict_t                        want;
  } step_row_t;

  logic clk;
  logic rst_n;
  logic                            cfg_we;
  logic [iigad_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [iigad_pkg::CFG_W-1:0]     cfg_wdata;

  iigad_in_if  in_ch ();
  iigad_out_if out_ch ();

  imu_impact_gyro_anomaly_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Detector model state and register mirror.
  logic [15:0]                     imp_limit;
  logic [15:0]                     rate_limit;
  logic [7:0]                      run_needed;
  logic [iigad_pkg::RUN_W-1:0]     impact_streak;
  logic                            impact_fired;
  logic [iigad_pkg::RUN_W-1:0]     gyro_streak;
  logic [iigad_pkg::HOLDOFF_W-1:0] gyro_quiet;

  verdict_t   alerts_pending [$];
  verdict_t   head;
  step_row_t  plan [$];

  int          errors;
  int          samples_sent;
  int          results_seen;
  int          impact_seen;
  int          gyro_seen;
  int          phases_run;
  int          idle_cycles;
  int unsigned burst_left;
  int unsigned acc_left;
  int unsigned rate_left;
  int unsigned disarm_left;
  int unsigned rx_left;
  shape_t      acc_shape;
  shape_t      rate_shape;
  rx_mode_t    rx_mode;
  bit          hold_req;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic logic [16:0] rate_mag(input logic signed [15:0] r);
    logic signed [16:0] w;
    w = 17'(r);
    return (w < 0) ? 17'(-w) : 17'(w);
  endfunction

  function automatic logic [31:0] square(input logic signed [15:0] a);
    logic signed [31:0] w;
    w = 32'(a);
    return w * w;
  endfunction

  function automatic verdict_t detect_step(input sample_t s);
    verdict_t    v;
    logic [16:0] mag [3];
    logic [16:0] top;
    logic [33:0] energy;
    logic [33:0] limit_sq;
    mag[0] = rate_mag(s.rx);
    mag[1] = rate_mag(s.ry);
    mag[2] = rate_mag(s.rz);
    v = '0;
    v.peak = iigad_pkg::AXIS_X;
    top = '0;
    for (int i = 0; i < 3; i++) begin
      if (mag[i] > top) begin
        top = mag[i];
        v.peak = AXIS_CODE[i];
      end
    end
    if (!s.armed) begin
      impact_streak = '0;
      impact_fired  = 1'b0;
      gyro_streak   = '0;
      gyro_quiet    = '0;
    end else begin
      energy   = 34'(square(s.ax)) + 34'(square(s.ay)) + 34'(square(s.az));
      limit_sq = 34'(imp_limit) * 34'(imp_limit);
      if (energy > limit_sq) begin
        if (impact_streak != iigad_pkg::RUN_MAX) impact_streak++;
        if (impact_streak >= run_needed && !impact_fired) begin
          impact_fired = 1'b1;
          v.impact = 1'b1;
        end
      end else begin
        impact_streak = '0;
      end
      if (gyro_quiet != 0) gyro_quiet--;
      if (top > 17'(rate_limit)) begin
        if (gyro_streak != iigad_pkg::RUN_MAX) gyro_streak++;
        if (gyro_streak >= run_needed && gyro_quiet == 0) begin
          v.gyro = 1'b1;
          gyro_streak = '0;
          gyro_quiet = iigad_pkg::HOLDOFF_SAMPLES;
        end
      end else begin
        gyro_streak = '0;
      end
    end
    return v;
  endfunction

  function automatic logic [15:0] signed_of(input int unsigned m, input bit neg);
    if (m >= 32768) return 16'h8000;
    return neg ? 16'(-int'(m)) : 16'(m);
  endfunction

  function automatic logic [47:0] axis_triple(input shape_t sh, input int unsigned lim,
                                              input bit is_rate);
    logic [15:0] v [3];
    int unsigned cap;
    int unsigned m;
    int unsigned k;
    k = $urandom_range(2, 0);
    for (int i = 0; i < 3; i++) v[i] = 16'($urandom);
    case (sh)
      SHAPE_QUIET: begin
        cap = is_rate ? lim : lim / 2;
        if (cap > 32768) cap = 32768;
        for (int i = 0; i < 3; i++)
          v[i] = signed_of($urandom_range(cap, 0), 1'($urandom_range(1, 0)));
      end
      SHAPE_HIT: begin
        if (lim < 32768)
          v[k] = signed_of($urandom_range(32768, lim + 1), 1'($urandom_range(1, 0)));
      end
      SHAPE_EDGE: begin
        m = lim + $urandom_range(1, 0);
        if (m > 32768) m = 32768;
        for (int i = 0; i < 3; i++) begin
          if (is_rate) v[i] = signed_of(m, 1'($urandom_range(1, 0)));
          else v[i] = '0;
        end
        v[k] = signed_of(m, 1'($urandom_range(1, 0)));
      end
      default: ;
    endcase
    return {v[2], v[1], v[0]};
  endfunction

  function automatic shape_t pick_shape();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 40) return SHAPE_QUIET;
    if (r < 75) return SHAPE_HIT;
    if (r < 85) return SHAPE_EDGE;
    return SHAPE_NOISE;
  endfunction

  function automatic int unsigned run_len();
    if ($urandom_range(15, 0) == 0) return $urandom_range(600, 250);
    return $urandom_range(int'(run_needed) + 3, 1);
  endfunction

  function automatic sample_t next_random_sample();
    sample_t     s;
    logic [47:0] a;
    logic [47:0] r;
    if (acc_left == 0) begin
      acc_shape = pick_shape();
      acc_left  = run_len();
    end
    if (rate_left == 0) begin
      rate_shape = pick_shape();
      rate_left  = run_len();
    end
    acc_left--;
    rate_left--;
    a = axis_triple(acc_shape, int'(imp_limit), 1'b0);
    r = axis_triple(rate_shape, int'(rate_limit), 1'b1);
    {s.az, s.ay, s.ax} = a;
    {s.rz, s.ry, s.rx} = r;
    if (disarm_left != 0) begin
      disarm_left--;
      s.armed = 1'b0;
    end else if ($urandom_range(249, 0) == 0) begin
      disarm_left = $urandom_range(4, 0);
      s.armed = 1'b0;
    end else begin
      s.armed = 1'b1;
    end
    return s;
  endfunction

  function automatic step_row_t smp_row(input int ax, ay, az, rx, ry, rz,
                                        input bit armed, typed, imp, gyr,
                                        input logic [1:0] peak);
    step_row_t row;
    row.kind  = ROW_SAMPLE;
    row.idx   = '0;
    row.data  = '0;
    row.smp   = '{16'(ax), 16'(ay), 16'(az), 16'(rx), 16'(ry), 16'(rz), armed};
    row.typed = typed;
    row.want  = '{imp, gyr, peak};
    return row;
  endfunction

  function automatic step_row_t set_row(input logic [iigad_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [iigad_pkg::CFG_W-1:0] data);
    step_row_t row;
    row.kind  = ROW_SETTING;
    row.idx   = idx;
    row.data  = data;
    row.smp   = '0;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  task automatic drain();
    in_ch.valid = 1'b0;
    while (alerts_pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_setting(input logic [iigad_pkg::CFG_IDX_W-1:0] idx,
                               input logic [iigad_pkg::CFG_W-1:0] data);
    drain();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      iigad_pkg::CFG_IMPACT_THR:  imp_limit  = data;
      iigad_pkg::CFG_GYRO_THR:    rate_limit = data;
      iigad_pkg::CFG_CONSEC_NEED: run_needed = data[7:0];
      default: ;
    endcase
  endtask

  task automatic offer(input sample_t s, input bit typed, input verdict_t want);
    int unsigned gap;
    verdict_t    v;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(150, 60) : $urandom_range(12, 1);
    end
    in_ch.accel_x = s.ax;
    in_ch.accel_y = s.ay;
    in_ch.accel_z = s.az;
    in_ch.rate_x  = s.rx;
    in_ch.rate_y  = s.ry;
    in_ch.rate_z  = s.rz;
    in_ch.armed   = s.armed;
    in_ch.valid   = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    v = detect_step(s);
    alerts_pending.push_back(typed ? want : v);
    samples_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] imp, input logic [15:0] gyr, input logic [7:0] need,
                           input int count, input bit squeeze);
    write_setting(iigad_pkg::CFG_IMPACT_THR, imp);
    write_setting(iigad_pkg::CFG_GYRO_THR, gyr);
    write_setting(iigad_pkg::CFG_CONSEC_NEED, {8'd0, need});
    phases_run++;
    for (int n = 0; n < count; n++) begin
      if (squeeze && n == count / 3) hold_req = 1'b1;
      if (n == (2 * count) / 3) drain();
      offer(next_random_sample(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (alerts_pending.size() == 0) begin
        flag($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        head = alerts_pending.pop_front();
        if (out_ch.impact_alert !== head.impact)
          flag($sformatf("result %0d impact_alert %b, want %b", results_seen,
                         out_ch.impact_alert, head.impact));
        if (out_ch.gyro_alert !== head.gyro)
          flag($sformatf("result %0d gyro_alert %b, want %b", results_seen,
                         out_ch.gyro_alert, head.gyro));
        if (out_ch.peak_axis !== head.peak)
          flag($sformatf("result %0d peak_axis %0d, want %0d", results_seen,
                         out_ch.peak_axis, head.peak));
        if (head.impact) impact_seen++;
        if (head.gyro) gyro_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(2, 0));
        rx_left = $urandom_range(200, 30);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:  out_ch.ready = 1'b1;
        RX_BUSY:  out_ch.ready = ($urandom_range(9, 0) < 7);
        default:  out_ch.ready = ($urandom_range(9, 0) < 3);
      endcase
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    in_ch.rate_x  = '0;
    in_ch.rate_y  = '0;
    in_ch.rate_z  = '0;
    in_ch.armed   = 1'b0;
    out_ch.ready  = 1'b0;
    imp_limit     = iigad_pkg::IMPACT_THR_RST;
    rate_limit    = iigad_pkg::GYRO_THR_RST;
    run_needed    = iigad_pkg::CONSEC_NEED_RST;
    impact_streak = '0;
    impact_fired  = 1'b0;
    gyro_streak   = '0;
    gyro_quiet    = '0;
    errors        = 0;
    samples_sent  = 0;
    results_seen  = 0;
    impact_seen   = 0;
    gyro_seen     = 0;
    phases_run    = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    acc_left      = 0;
    rate_left     = 0;
    disarm_left   = 0;
    rx_left       = 0;
    rx_mode       = RX_OPEN;
    hold_req      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    plan.push_back(set_row(CFG_SPARE, 16'hFFFF));
    plan.push_back(smp_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, iigad_pkg::AXIS_X));
    plan.push_back(smp_row(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, iigad_pkg::AXIS_X));
    plan.push_back(smp_row(16384, 0, 0, 12800, 12800, 12800, 1, 1, 0, 0, iigad_pkg::AXIS_X));
    plan.push_back(smp_row(-32768, -32768, -32768, 0, -32768, 32767, 1, 1, 0, 0,
                           iigad_pkg::AXIS_Y));
    plan.push_back(smp_row(-32768, -32768, -32768, 0, -32768, 32767, 1, 1, 1, 1,
                           iigad_pkg::AXIS_Y));
    plan.push_back(smp_row(-32768, -32768, -32768, 0, -32768, 32767, 1, 0, 0, 0,
                           iigad_pkg::AXIS_X));
    plan.push_back(smp_row(-32768, -32768, -32768, 0, 32767, 32767, 1, 0, 0, 0,
                           iigad_pkg::AXIS_X));
    plan.push_back(smp_row(32767, 32767, 32767, -32768, 5, -7, 0, 1, 0, 0, iigad_pkg::AXIS_X));
    plan.push_back(smp_row(-32768, -32768, -32768, -32768, 0, 0, 1, 1, 0, 0,
                           iigad_pkg::AXIS_X));
    plan.push_back(smp_row(-32768, -32768, -32768, -32768, 0, 0, 1, 1, 1, 1,
                           iigad_pkg::AXIS_X));
    plan.push_back(set_row(iigad_pkg::CFG_CONSEC_NEED, 16'd0));
    plan.push_back(smp_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, iigad_pkg::AXIS_X));
    plan.push_back(smp_row(32767, 0, 0, 100, -200, 300, 1, 1, 1, 0, iigad_pkg::AXIS_Z));
    plan.push_back(smp_row(0, 0, 0, 12801, 0, 0, 1, 1, 0, 1, iigad_pkg::AXIS_X));
    plan.push_back(set_row(iigad_pkg::CFG_GYRO_THR, 16'd32768));
    plan.push_back(set_row(iigad_pkg::CFG_CONSEC_NEED, 16'd1));
    plan.push_back(smp_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, iigad_pkg::AXIS_X));
    plan.push_back(smp_row(0, -16384, 0, -32768, 0, 0, 1, 1, 0, 0, iigad_pkg::AXIS_X));
    plan.push_back(set_row(iigad_pkg::CFG_GYRO_THR, 16'd32767));
    plan.push_back(smp_row(0, 0, 0, -32768, 0, 0, 1, 1, 0, 1, iigad_pkg::AXIS_X));
    plan.push_back(smp_row(0, 0, 0, -32768, 0, 0, 1, 1, 0, 0, iigad_pkg::AXIS_X));
    plan.push_back(set_row(iigad_pkg::CFG_IMPACT_THR, 16'd0));
    plan.push_back(set_row(iigad_pkg::CFG_GYRO_THR, 16'd0));
    plan.push_back(smp_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, iigad_pkg::AXIS_X));
    plan.push_back(smp_row(0, 0, 1, 0, 0, -1, 1, 1, 1, 1, iigad_pkg::AXIS_Z));
    plan.push_back(smp_row(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, iigad_pkg::AXIS_X));
    plan.push_back(smp_row(1, -1, 1, 1, -1, -1, 1, 0, 0, 0, iigad_pkg::AXIS_X));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETTING) write_setting(plan[i].idx, plan[i].data);
      else offer(plan[i].smp, plan[i].typed, plan[i].want);
    end

    run_phase(16'd16384, 16'd12800, 8'd2, 350, 1'b1);
    run_phase(16'd0, 16'd0, 8'd1, 150, 1'b0);
    run_phase(16'd65535, 16'd32767, 8'd255, 700, 1'b1);
    run_phase(16'd32768, 16'd32768, 8'd0, 200, 1'b0);
    run_phase(16'($urandom_range(40000, 1000)), 16'($urandom_range(32768, 500)),
              8'($urandom_range(6, 1)), 300, 1'b1);
    run_phase(16'($urandom_range(40000, 1000)), 16'($urandom_range(32768, 500)),
              8'($urandom_range(6, 1)), 300, 1'b0);

    drain();
    repeat (8) @(negedge clk);
    $display("Sent %0d samples (directed list plus %0d random phases); checked %0d results.",
             samples_sent, phases_run, results_seen);
    $display("Alerts raised: %0d impact, %0d gyro; mismatches: %0d.",
             impact_seen, gyro_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/iigad_pkg.sv
sv/iigad_in_if.sv
sv/iigad_out_if.sv
sv/iigad_feature.sv
sv/imu_impact_gyro_anomaly_detector.sv
tb/tb_top.sv
